[hw/rtl/replica_source_priority_selector_assert.svh]
// ----------------------------------------------------------------------------
// replica_source_priority_selector assertion macros
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef REPLICA_SOURCE_PRIORITY_SELECTOR_ASSERT_SVH
`define REPLICA_SOURCE_PRIORITY_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every rising clk_i edge outside reset
`define RSPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsps assertion failed");

// condition that must never be true outside reset
`define RSPS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rsps forbidden condition seen");

`else

`define RSPS_ASSERT(lbl, prop)
`define RSPS_NEVER(lbl, cond)

`endif

`endif

[hw/rtl/rsps_pkg.sv]
// ----------------------------------------------------------------------------
// rsps_pkg
// Types and constants shared by the replica source priority selector.
// ----------------------------------------------------------------------------
package rsps_pkg;

  localparam int MaxReplicasDef = 16;

  // replica kind codes
  localparam logic [2:0] KIND_MEMORY      = 3'd0;
  localparam logic [2:0] KIND_NOF         = 3'd1;
  localparam logic [2:0] KIND_LOCAL_DISK  = 3'd2;
  localparam logic [2:0] KIND_REMOTE_DISK = 3'd3;

  // protocol tags
  localparam logic [1:0] PROTO_NONE   = 2'd0;
  localparam logic [1:0] PROTO_NVLINK = 2'd1;
  localparam logic [1:0] PROTO_RDMA   = 2'd2;

  // candidate slots
  localparam int HIT_LOCAL_MEM  = 0;
  localparam int HIT_NVLINK     = 1;
  localparam int HIT_RDMA       = 2;
  localparam int HIT_LEGACY_MEM = 3;
  localparam int HIT_NOF        = 4;
  localparam int HIT_DISK       = 5;
  localparam int NumHits        = 6;

  // configuration register indexes
  localparam logic [1:0] REG_NVLINK_NUMA_ENABLE = 2'd0;
  localparam logic [1:0] REG_DEST_IS_DEVICE     = 2'd1;
  localparam logic [1:0] REG_LOCAL_DOMAIN_ID    = 2'd2;

  localparam int AddrW = 4;

  typedef struct packed {
    logic        nvlink_numa_enable;
    logic        dest_is_device;
    logic [15:0] local_domain_id;
  } rsps_cfg_t;

  typedef struct packed {
    logic        is_complete;
    logic [2:0]  replica_kind;
    logic        endpoint_is_local;
    logic        has_nvlink;
    logic        has_rdma;
    logic        multi_protocol;
    logic        is_host_numa;
    logic [15:0] replica_domain_id;
    logic        last_replica;
  } rsps_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] chosen_index;
    logic [1:0] chosen_protocol;
  } rsps_result_t;

endpackage

[hw/rtl/rsps_cfg.sv]
// ----------------------------------------------------------------------------
// rsps_cfg
// APB register file holding the selector configuration.
// ----------------------------------------------------------------------------
module rsps_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rsps_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output rsps_pkg::rsps_cfg_t       cfg_o
);

  rsps_pkg::rsps_cfg_t cfg_q, cfg_d;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rsps_pkg::REG_NVLINK_NUMA_ENABLE: cfg_d.nvlink_numa_enable = pwdata[0];
        rsps_pkg::REG_DEST_IS_DEVICE:     cfg_d.dest_is_device     = pwdata[0];
        rsps_pkg::REG_LOCAL_DOMAIN_ID:    cfg_d.local_domain_id    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rsps_pkg::REG_NVLINK_NUMA_ENABLE: prdata = {31'd0, cfg_q.nvlink_numa_enable};
      rsps_pkg::REG_DEST_IS_DEVICE:     prdata = {31'd0, cfg_q.dest_is_device};
      rsps_pkg::REG_LOCAL_DOMAIN_ID:    prdata = {16'd0, cfg_q.local_domain_id};
      default:                          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/rsps_in_stage.sv]
// ----------------------------------------------------------------------------
// rsps_in_stage
// Input register for replica descriptors with stream handshake.
// ----------------------------------------------------------------------------
module rsps_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rsps_pkg::rsps_item_t   in_item_i,
  output logic                   item_valid_o,
  input  logic                   item_take_i,
  output rsps_pkg::rsps_item_t   item_o
);

  logic                 vld_q, vld_d;
  rsps_pkg::rsps_item_t item_q;
  logic                 load;

  assign in_ready_o = !vld_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (item_take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

[hw/rtl/rsps_scan.sv]
// ----------------------------------------------------------------------------
// rsps_scan
// First-found candidate registers and the priority pick on the last item.
// ----------------------------------------------------------------------------
module rsps_scan #(
  parameter int MAX_REPLICAS = rsps_pkg::MaxReplicasDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  rsps_pkg::rsps_item_t   item_i,
  input  rsps_pkg::rsps_cfg_t    cfg_i,
  output rsps_pkg::rsps_result_t result_o
);

  localparam int IdxW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int PosW = $clog2(MAX_REPLICAS + 1);
  localparam int NH   = rsps_pkg::NumHits;

  logic [PosW-1:0] pos_q, pos_d;
  logic [NH-1:0]   vld_q, vld_d, vld_u;
  logic [NH-1:0]   mul_q, mul_d, mul_u;
  logic [IdxW-1:0] idx_q [NH];
  logic [IdxW-1:0] idx_d [NH];
  logic [IdxW-1:0] idx_u [NH];

  logic            in_range;
  logic            is_mem;
  logic            nvl_ok;
  logic [IdxW-1:0] cur_idx;
  logic [NH-1:0]   take;
  logic [IdxW-1:0] win_idx;

  assign in_range = pos_q < PosW'(MAX_REPLICAS);
  assign cur_idx  = pos_q[IdxW-1:0];
  assign is_mem   = item_i.replica_kind == rsps_pkg::KIND_MEMORY;
  assign nvl_ok   = cfg_i.nvlink_numa_enable && cfg_i.dest_is_device &&
                    item_i.has_nvlink && item_i.is_host_numa &&
                    (item_i.replica_domain_id == cfg_i.local_domain_id);

  // first-found slots take the item when still empty
  always_comb begin
    take = '0;
    if (item_i.is_complete && in_range) begin
      take[rsps_pkg::HIT_LOCAL_MEM]  = is_mem && item_i.endpoint_is_local;
      take[rsps_pkg::HIT_NVLINK]     = is_mem && nvl_ok;
      take[rsps_pkg::HIT_RDMA]       = is_mem && item_i.has_rdma;
      take[rsps_pkg::HIT_LEGACY_MEM] = is_mem && !item_i.has_nvlink && !item_i.has_rdma;
      take[rsps_pkg::HIT_NOF]        = item_i.replica_kind == rsps_pkg::KIND_NOF;
      take[rsps_pkg::HIT_DISK]       = item_i.replica_kind == rsps_pkg::KIND_REMOTE_DISK;
    end
  end

  always_comb begin
    vld_u = vld_q;
    mul_u = mul_q;
    idx_u = idx_q;
    for (int i = 0; i < NH; i++) begin
      if (take[i] && !vld_q[i]) begin
        vld_u[i] = 1'b1;
        idx_u[i] = cur_idx;
        mul_u[i] = item_i.multi_protocol &&
                   (i != rsps_pkg::HIT_NOF) && (i != rsps_pkg::HIT_DISK);
      end
    end
    // a complete, in-range local disk always overrides the disk slot
    if (item_i.is_complete && in_range &&
        item_i.replica_kind == rsps_pkg::KIND_LOCAL_DISK) begin
      vld_u[rsps_pkg::HIT_DISK] = 1'b1;
      idx_u[rsps_pkg::HIT_DISK] = cur_idx;
      mul_u[rsps_pkg::HIT_DISK] = 1'b0;
    end
  end

  always_comb begin
    result_o = '0;
    win_idx  = '0;
    result_o.found = |vld_u;
    if (vld_u[rsps_pkg::HIT_LOCAL_MEM]) begin
      win_idx = idx_u[rsps_pkg::HIT_LOCAL_MEM];
    end else if (vld_u[rsps_pkg::HIT_NVLINK]) begin
      win_idx = idx_u[rsps_pkg::HIT_NVLINK];
      if (mul_u[rsps_pkg::HIT_NVLINK]) begin
        result_o.chosen_protocol = rsps_pkg::PROTO_NVLINK;
      end
    end else if (vld_u[rsps_pkg::HIT_RDMA]) begin
      win_idx = idx_u[rsps_pkg::HIT_RDMA];
      if (mul_u[rsps_pkg::HIT_RDMA]) begin
        result_o.chosen_protocol = rsps_pkg::PROTO_RDMA;
      end
    end else if (vld_u[rsps_pkg::HIT_LEGACY_MEM]) begin
      win_idx = idx_u[rsps_pkg::HIT_LEGACY_MEM];
    end else if (vld_u[rsps_pkg::HIT_NOF]) begin
      win_idx = idx_u[rsps_pkg::HIT_NOF];
    end else if (vld_u[rsps_pkg::HIT_DISK]) begin
      win_idx = idx_u[rsps_pkg::HIT_DISK];
    end
    result_o.chosen_index = 4'(win_idx);
  end

  always_comb begin
    pos_d = pos_q;
    vld_d = vld_q;
    mul_d = mul_q;
    idx_d = idx_q;
    if (fire_i) begin
      if (item_i.last_replica) begin
        pos_d = '0;
        vld_d = '0;
      end else begin
        pos_d = in_range ? pos_q + PosW'(1) : pos_q;
        vld_d = vld_u;
        mul_d = mul_u;
        idx_d = idx_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= '0;
    end else begin
      pos_q <= pos_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    idx_q <= idx_d;
  end

endmodule

[hw/rtl/replica_source_priority_selector.sv]
// ----------------------------------------------------------------------------
// replica_source_priority_selector
// Picks a transfer source from a list of replica descriptors by fixed priority.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  s_axis   | in        | tvalid / tready   | tdata flags + domain, tuser kind, tlast
//  m_axis   | out       | tvalid / tready   | tdata found, index, protocol
//  apb      | in        | psel/penable      | three config registers at 0x0, 0x4, 0x8
//
//  one descriptor per cycle unless a last descriptor waits; once its last descriptor
//  is accepted, a result passes the input register, then the result register
//  the input register drains a non-last descriptor every cycle; a last
//  descriptor waits only while the result register is full and not taken
//  rst_ni clears the scan state, the config registers and both valid flags
// ----------------------------------------------------------------------------
`include "replica_source_priority_selector_assert.svh"

module replica_source_priority_selector #(
  parameter int MAX_REPLICAS = rsps_pkg::MaxReplicasDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] is_complete, [1] endpoint_is_local, [2] has_nvlink, [3] has_rdma,
  // [4] multi_protocol, [5] is_host_numa, [21:6] replica_domain_id, [23:22] unused
  input  logic [23:0]                s_axis_tdata,
  // [2:0] replica_kind
  input  logic [2:0]                 s_axis_tuser,
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] found, [4:1] chosen_index, [6:5] chosen_protocol, [7] zero
  output logic [7:0]                 m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsps_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  rsps_pkg::rsps_cfg_t    cfg;
  rsps_pkg::rsps_item_t   in_item;
  rsps_pkg::rsps_item_t   item;
  rsps_pkg::rsps_result_t result;
  rsps_pkg::rsps_result_t out_q;
  logic                   item_vld;
  logic                   fire;
  logic                   out_vld_q, out_vld_d;

  rsps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    in_item.is_complete       = s_axis_tdata[0];
    in_item.replica_kind      = s_axis_tuser;
    in_item.endpoint_is_local = s_axis_tdata[1];
    in_item.has_nvlink        = s_axis_tdata[2];
    in_item.has_rdma          = s_axis_tdata[3];
    in_item.multi_protocol    = s_axis_tdata[4];
    in_item.is_host_numa      = s_axis_tdata[5];
    in_item.replica_domain_id = s_axis_tdata[21:6];
    in_item.last_replica      = s_axis_tlast;
  end

  // a last request needs room in the result register
  assign fire = item_vld && (!item.last_replica || !out_vld_q || m_axis_tready);

  rsps_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_vld),
    .item_take_i  (fire),
    .item_o       (item)
  );

  rsps_scan #(
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire && item.last_replica) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && item.last_replica) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.chosen_protocol, out_q.chosen_index, out_q.found};

  `RSPS_ASSERT(a_last_gives_result, fire && item.last_replica |=> out_vld_q)
  `RSPS_ASSERT(a_empty_input_ready, !item_vld |-> s_axis_tready)
  `RSPS_NEVER(a_no_found_is_zero, out_vld_q && !out_q.found && (out_q.chosen_index != 4'd0 || out_q.chosen_protocol != rsps_pkg::PROTO_NONE))
  `RSPS_NEVER(a_protocol_code, out_vld_q && out_q.chosen_protocol != rsps_pkg::PROTO_NONE && out_q.chosen_protocol != rsps_pkg::PROTO_NVLINK && out_q.chosen_protocol != rsps_pkg::PROTO_RDMA)

endmodule
